// ===== hdl/bmpc_pkg.sv =====
// Shared types, constants and helpers of the barometer compensation pipeline.
// No dependencies; bmpc_temp, bmpc_press, bmpc_div, bmpc_post and the top module import this package.
package bmpc_pkg;

   localparam int RAW_W     = 20;
   localparam int DIV_W     = 64;

   // stage counts of each section
   localparam int TEMP_LAT  = 5;
   localparam int PRESS_LAT = 8;
   localparam int DIV_LAT   = DIV_W;
   localparam int POST_LAT  = 7;
   localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT + DIV_LAT + POST_LAT;

   localparam logic [63:0] T_OFFSET   = 64'd128000;
   localparam logic [20:0] P_FULL     = 21'd1048576;
   localparam logic [63:0] P_SCALE    = 64'd3125;
   localparam logic [63:0] C_ROUND    = 64'd128;
   localparam logic [63:0] W1_BIAS    = 64'h0000_8000_0000_0000;
   localparam logic [63:0] PA_MAX     = 64'd262143;

   typedef enum logic [1:0] {
      CSR_TEMP_COEFFS = 2'd0,
      CSR_PRESS_LOW   = 2'd1,
      CSR_PRESS_HIGH  = 2'd2,
      CSR_PRESS_NINE  = 2'd3
   } csr_index_type;

   // operands handed to the divider: magnitudes and the result sign
   typedef struct packed {
      logic [DIV_W-1:0] ua;
      logic [DIV_W-1:0] ub;
      logic             neg;
   } div_in_type;

   function automatic logic [31:0] sx16_32(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx16_64(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
      return 64'($signed(x) >>> n);
   endfunction

endpackage

// ===== hdl/bmpc_mul64.sv =====
// Two-stage 64x64 multiplier giving the product modulo 2^64.
// Built from three 32x32 partial products; no package dependencies.
module bmpc_mul64 (
   input  logic        clock,
   input  logic        ce,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, lh_in;
   logic [31:0] hl_ff, hl_in;
   logic [63:0] p_ff, p_in;

   assign ll_in = {32'b0, a[31:0]} * {32'b0, b[31:0]};
   assign lh_in = a[31:0] * b[63:32];
   assign hl_in = a[63:32] * b[31:0];
   // cross terms only matter in their low 32 bits
   assign p_in  = ll_ff + {lh_ff + hl_ff, 32'b0};

   always_ff @(posedge clock) begin
      if (ce) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== hdl/bmpc_dly.sv =====
// Enabled delay line that keeps side data aligned with the pipeline stages.
// No package dependencies.
module bmpc_dly #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             ce,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (ce) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

// ===== hdl/bmpc_temp.sv =====
// Temperature section: fine temperature, hundredths of a degree, and the
// pressure offset term. Five stages. Depends on bmpc_pkg and bmpc_dly.
module bmpc_temp (
   input  logic                     clock,
   input  logic                     ce,
   input  logic [19:0]              raw_temperature,
   input  logic [19:0]              raw_pressure,
   input  logic [47:0]              temp_coeffs,
   output logic [31:0]              fine_temperature,
   output logic [15:0]              temperature_centi,
   output logic [63:0]              w1,
   output logic [19:0]              raw_pressure_dly
);
   import bmpc_pkg::*;

   logic [31:0] t1, t2, t3;
   logic [31:0] a_ff, a_in, d_ff, d_in;
   logic [31:0] m1_ff, m1_in, dd_ff, dd_in;
   logic [31:0] v1_ff, v1_in, m3_ff, m3_in, dds;
   logic [31:0] tf_ff, tf_in;
   logic [63:0] tf64, t5, tcs;
   logic [31:0] tf5_ff;
   logic [15:0] tc_ff, tc_in;
   logic [63:0] w1_ff, w1_in;

   assign t1 = {16'b0, temp_coeffs[15:0]};
   assign t2 = sx16_32(temp_coeffs[31:16]);
   assign t3 = sx16_32(temp_coeffs[47:32]);

   assign a_in  = {15'b0, raw_temperature[19:3]} - {15'b0, temp_coeffs[15:0], 1'b0};
   assign d_in  = {16'b0, raw_temperature[19:4]} - t1;
   assign m1_in = a_ff * t2;
   assign dd_in = d_ff * d_ff;
   assign v1_in = 32'($signed(m1_ff) >>> 11);
   assign dds   = 32'($signed(dd_ff) >>> 12);
   assign m3_in = dds * t3;
   assign tf_in = v1_ff + 32'($signed(m3_ff) >>> 14);

   assign tf64  = {{32{tf_ff[31]}}, tf_ff};
   assign t5    = (tf64 << 2) + tf64 + C_ROUND;
   assign tcs   = asr64(t5, 8);
   assign w1_in = tf64 - T_OFFSET;

   always_comb begin
      if ($signed(tcs) < -64'sd32768) begin
         tc_in = 16'h8000;
      end else if ($signed(tcs) > 64'sd32767) begin
         tc_in = 16'h7fff;
      end else begin
         tc_in = tcs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff   <= a_in;
         d_ff   <= d_in;
         m1_ff  <= m1_in;
         dd_ff  <= dd_in;
         v1_ff  <= v1_in;
         m3_ff  <= m3_in;
         tf_ff  <= tf_in;
         tf5_ff <= tf_ff;
         tc_ff  <= tc_in;
         w1_ff  <= w1_in;
      end
   end

   bmpc_dly #(.WIDTH(RAW_W), .DEPTH(TEMP_LAT)) u_praw (
      .clock (clock),
      .ce    (ce),
      .d     (raw_pressure),
      .q     (raw_pressure_dly)
   );

   assign fine_temperature  = tf5_ff;
   assign temperature_centi = tc_ff;
   assign w1                = w1_ff;

endmodule

// ===== hdl/bmpc_press.sv =====
// Pressure section ahead of the divider: the two calibration polynomials,
// the scaled dividend and the divisor. Eight stages.
// Depends on bmpc_pkg, bmpc_mul64 and bmpc_dly.
module bmpc_press (
   input  logic                    clock,
   input  logic                    ce,
   input  logic [63:0]             w1,
   input  logic [19:0]             raw_pressure,
   input  logic [63:0]             press_coeffs_low,
   input  logic [63:0]             press_coeffs_high,
   output bmpc_pkg::div_in_type    div_in,
   output logic                    divisor_zero
);
   import bmpc_pkg::*;

   logic [63:0] p1, p2, p3, p4, p5, p6;
   logic [63:0] sq, q5, q2, q5d, q2d, w2a, w1a;
   logic [63:0] w2_ff, w2_in, x_ff, x_in;
   logic [19:0] praw;
   logic [20:0] pbase;
   logic [63:0] n0, num, w1c, w1d;
   logic        dz;
   div_in_type  div_ff, div_nx;
   logic        dz_ff;

   assign p1 = {48'b0, press_coeffs_low[15:0]};
   assign p2 = sx16_64(press_coeffs_low[31:16]);
   assign p3 = sx16_64(press_coeffs_low[47:32]);
   assign p4 = sx16_64(press_coeffs_low[63:48]);
   assign p5 = sx16_64(press_coeffs_high[15:0]);
   assign p6 = sx16_64(press_coeffs_high[31:16]);

   bmpc_mul64 u_sq  (.clock(clock), .ce(ce), .a(w1), .b(w1), .p(sq));
   bmpc_mul64 u_q5  (.clock(clock), .ce(ce), .a(w1), .b(p5), .p(q5));
   bmpc_mul64 u_q2  (.clock(clock), .ce(ce), .a(w1), .b(p2), .p(q2));

   bmpc_mul64 u_w2a (.clock(clock), .ce(ce), .a(sq), .b(p6), .p(w2a));
   bmpc_mul64 u_w1a (.clock(clock), .ce(ce), .a(sq), .b(p3), .p(w1a));

   bmpc_dly #(.WIDTH(128), .DEPTH(2)) u_qd (
      .clock (clock),
      .ce    (ce),
      .d     ({q5, q2}),
      .q     ({q5d, q2d})
   );

   assign w2_in = w2a + (q5d << 17) + (p4 << 35);
   assign x_in  = W1_BIAS + asr64(w1a, 8) + (q2d << 12);

   // raw pressure waits until the dividend is formed
   bmpc_dly #(.WIDTH(RAW_W), .DEPTH(5)) u_praw (
      .clock (clock),
      .ce    (ce),
      .d     (raw_pressure),
      .q     (praw)
   );

   assign pbase = P_FULL - {1'b0, praw};
   assign n0    = ({43'b0, pbase} << 31) - w2_ff;

   bmpc_mul64 u_w1c (.clock(clock), .ce(ce), .a(x_ff), .b(p1),      .p(w1c));
   bmpc_mul64 u_num (.clock(clock), .ce(ce), .a(n0),   .b(P_SCALE), .p(num));

   assign w1d = asr64(w1c, 33);
   assign dz  = (w1d == 64'd0);

   always_comb begin
      div_nx.ua  = num[63] ? (64'd0 - num) : num;
      // keep the divider busy with a harmless divisor on a zero divisor
      div_nx.ub  = dz ? 64'd1 : (w1d[63] ? (64'd0 - w1d) : w1d);
      div_nx.neg = num[63] ^ w1d[63];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         w2_ff  <= w2_in;
         x_ff   <= x_in;
         div_ff <= div_nx;
         dz_ff  <= dz;
      end
   end

   assign div_in       = div_ff;
   assign divisor_zero = dz_ff;

endmodule

// ===== hdl/bmpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned
// magnitudes with the result sign carried along. Depends on bmpc_pkg.
module bmpc_div (
   input  logic                    clock,
   input  logic                    ce,
   input  bmpc_pkg::div_in_type    din,
   output logic [63:0]             quotient,
   output logic                    neg
);
   import bmpc_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_LAT];
   logic [DIV_W-1:0] quo_ff [DIV_LAT];
   logic [DIV_W-1:0] dvs_ff [DIV_LAT];
   logic             neg_ff [DIV_LAT];

   for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
      logic [DIV_W-1:0] rem_prev, quo_prev, dvs_prev;
      logic             neg_prev;
      logic [DIV_W:0]   diff_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = din.ua;
         assign dvs_prev = din.ub;
         assign neg_prev = din.neg;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign dvs_prev = dvs_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      assign diff_in = {rem_prev, quo_prev[DIV_W-1]} - {1'b0, dvs_prev};

      always_ff @(posedge clock) begin
         if (ce) begin
            if (!diff_in[DIV_W]) begin
               rem_ff[i] <= diff_in[DIV_W-1:0];
               quo_ff[i] <= {quo_prev[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= {rem_prev[DIV_W-2:0], quo_prev[DIV_W-1]};
               quo_ff[i] <= {quo_prev[DIV_W-2:0], 1'b0};
            end
            dvs_ff[i] <= dvs_prev;
            neg_ff[i] <= neg_prev;
         end
      end
   end

   assign quotient = quo_ff[DIV_LAT-1];
   assign neg      = neg_ff[DIV_LAT-1];

endmodule

// ===== hdl/bmpc_post.sv =====
// Pressure section after the divider: second-order correction, offset and
// clamp to whole pascals. Seven stages.
// Depends on bmpc_pkg, bmpc_mul64 and bmpc_dly.
module bmpc_post (
   input  logic        clock,
   input  logic        ce,
   input  logic [63:0] quotient,
   input  logic        neg,
   input  logic [63:0] press_coeffs_high,
   input  logic [15:0] press_coeff_nine,
   output logic [17:0] pressure_pa
);
   import bmpc_pkg::*;

   logic [63:0] p7, p8, p9;
   logic [63:0] p_ff, p_in, ph;
   logic [63:0] hh, e2m, e1m, e2d, pd2, pd4;
   logic [63:0] psum, s_ff, s_in;
   logic [17:0] pa_ff, pa_in;

   assign p7 = sx16_64(press_coeffs_high[47:32]);
   assign p8 = sx16_64(press_coeffs_high[63:48]);
   assign p9 = sx16_64(press_coeff_nine);

   assign p_in = neg ? (64'd0 - quotient) : quotient;
   assign ph   = asr64(p_ff, 13);

   bmpc_mul64 u_hh  (.clock(clock), .ce(ce), .a(ph),   .b(ph), .p(hh));
   bmpc_mul64 u_e2  (.clock(clock), .ce(ce), .a(p_ff), .b(p8), .p(e2m));
   bmpc_mul64 u_e1  (.clock(clock), .ce(ce), .a(hh),   .b(p9), .p(e1m));

   bmpc_dly #(.WIDTH(64), .DEPTH(2)) u_pd2 (
      .clock (clock),
      .ce    (ce),
      .d     (p_ff),
      .q     (pd2)
   );

   bmpc_dly #(.WIDTH(128), .DEPTH(2)) u_pd4 (
      .clock (clock),
      .ce    (ce),
      .d     ({pd2, e2m}),
      .q     ({pd4, e2d})
   );

   assign psum = pd4 + asr64(e1m, 25) + asr64(e2d, 19);
   assign s_in = asr64(psum, 8) + (p7 << 4);

   always_comb begin
      if (s_ff[63]) begin
         pa_in = 18'd0;
      end else if ({8'b0, s_ff[63:8]} > PA_MAX) begin
         pa_in = 18'h3ffff;
      end else begin
         pa_in = s_ff[25:8];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p_ff  <= p_in;
         s_ff  <= s_in;
         pa_ff <= pa_in;
      end
   end

   assign pressure_pa = pa_ff;

endmodule

// ===== hdl/baro_temp_pressure_compensation.sv =====
// Integer temperature and pressure compensation for a 20-bit barometer.
// One raw temperature/pressure pair enters per cycle while the pipeline is not
// held, and throughput is one transaction per clock, set by the fully
// pipelined datapath, with the 64-stage bit-per-stage divider dominating the
// latency. The whole pipeline holds while a result waits on rsp_tready, so
// no transaction is lost or repeated. The user must write calibration words
// over the csr_ port only while the pipeline is empty; the block does not enforce
// it. A zero pressure divisor raises rsp_tuser and returns zero pascals.
// Depends on bmpc_pkg, bmpc_temp, bmpc_press, bmpc_div, bmpc_post, bmpc_dly.
module baro_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // fine_temperature[31:0], temperature_centi[47:32],
                                    // pressure_pa[65:48], zero fill[71:66]
   output logic        rsp_tuser,   // divisor_zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import bmpc_pkg::*;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff, press_high_ff;
   logic [15:0] press_nine_ff;
   logic [TOTAL_LAT-1:0] valid_ff, valid_in;
   logic        ce;

   logic [31:0] tf5;
   logic [15:0] tc5;
   logic [63:0] w1;
   logic [19:0] praw5;
   div_in_type  div_in;
   logic        dz13, dz_out;
   logic [63:0] quo;
   logic        quo_neg;
   logic [17:0] pa;
   logic [31:0] tf_out;
   logic [15:0] tc_out;

   // advance everything unless a finished result is stuck at the output
   assign ce         = !valid_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = ce;
   assign valid_in   = {valid_ff[TOTAL_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_nine_ff  <= '0;
      end else begin
         if (ce) begin
            valid_ff <= valid_in;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata[47:0];
               CSR_PRESS_LOW:   press_low_ff   <= csr_wdata;
               CSR_PRESS_HIGH:  press_high_ff  <= csr_wdata;
               CSR_PRESS_NINE:  press_nine_ff  <= csr_wdata[15:0];
               default:         press_nine_ff  <= press_nine_ff;
            endcase
         end
      end
   end

   bmpc_temp u_temp (
      .clock             (clock),
      .ce                (ce),
      .raw_temperature   (req_tdata[19:0]),
      .raw_pressure      (req_tdata[39:20]),
      .temp_coeffs       (temp_coeffs_ff),
      .fine_temperature  (tf5),
      .temperature_centi (tc5),
      .w1                (w1),
      .raw_pressure_dly  (praw5)
   );

   bmpc_press u_press (
      .clock             (clock),
      .ce                (ce),
      .w1                (w1),
      .raw_pressure      (praw5),
      .press_coeffs_low  (press_low_ff),
      .press_coeffs_high (press_high_ff),
      .div_in            (div_in),
      .divisor_zero      (dz13)
   );

   bmpc_div u_div (
      .clock    (clock),
      .ce       (ce),
      .din      (div_in),
      .quotient (quo),
      .neg      (quo_neg)
   );

   bmpc_post u_post (
      .clock             (clock),
      .ce                (ce),
      .quotient          (quo),
      .neg               (quo_neg),
      .press_coeffs_high (press_high_ff),
      .press_coeff_nine  (press_nine_ff),
      .pressure_pa       (pa)
   );

   bmpc_dly #(.WIDTH(48), .DEPTH(TOTAL_LAT - TEMP_LAT)) u_tdly (
      .clock (clock),
      .ce    (ce),
      .d     ({tf5, tc5}),
      .q     ({tf_out, tc_out})
   );

   bmpc_dly #(.WIDTH(1), .DEPTH(DIV_LAT + POST_LAT)) u_zdly (
      .clock (clock),
      .ce    (ce),
      .d     (dz13),
      .q     (dz_out)
   );

   assign rsp_tvalid = valid_ff[TOTAL_LAT-1];
   assign rsp_tdata  = {6'b0, (dz_out ? 18'd0 : pa), tc_out, tf_out};
   assign rsp_tuser  = dz_out;

endmodule

// ===== bench/baro_temp_pressure_compensation_tb.sv =====
// Self-checking bench for baro_temp_pressure_compensation: drives raw readings,
// predicts each compensated result and compares it field by field.
// Depends on bmpc_pkg and the compensation RTL only.
module baro_temp_pressure_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmpc_pkg::*;

   typedef struct packed {
      logic [31:0] fine;
      logic [15:0] centi;
      logic [17:0] pascals;
      logic        div_zero;
   } comp_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // raw_temperature[19:0], raw_pressure[39:20]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;   // fine_temperature[31:0], temperature_centi[47:32],
                             // pressure_pa[65:48], zero fill[71:66]
   logic        rsp_tuser;   // divisor_zero
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   // calibration as the bench believes the block holds it
   logic [47:0] temp_cal;
   logic [63:0] press_cal_lo;
   logic [63:0] press_cal_hi;
   logic [15:0] press_cal_p9;

   comp_result_type pending_results[$];
   int          mismatch_count = 0;
   int          gap_pct;
   int          stall_pct;
   logic        req_ready_seen = 1'b0;

   baro_temp_pressure_compensation u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("baro_temp_pressure_compensation test failed");
      $finish;
   end

   function automatic logic [63:0] sar64(input logic [63:0] x, input int n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sar32(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic comp_result_type compensate(input logic [19:0] raw_t,
                                                  input logic [19:0] raw_p);
      comp_result_type r;
      logic [31:0] t1, t2, t3, a, v1, d, v2, tf;
      logic [63:0] tf64, tc, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] w1, w2, p, ph, e1, e2, num, ua, ub, q;
      logic        na, nb;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      a  = ({12'd0, raw_t} >> 3) - (t1 << 1);
      v1 = sar32(a * t2, 11);
      d  = ({12'd0, raw_t} >> 4) - t1;
      v2 = sar32(sar32(d * d, 12) * t3, 14);
      tf = v1 + v2;
      tf64 = {{32{tf[31]}}, tf};
      tc = sar64(tf64 * 64'd5 + 64'd128, 8);
      if ($signed(tc) < -64'sd32768) tc = -64'sd32768;
      else if ($signed(tc) > 64'sd32767) tc = 64'd32767;
      r.fine  = tf;
      r.centi = tc[15:0];

      p1 = {48'd0, press_cal_lo[15:0]};
      p2 = sext16(press_cal_lo[31:16]);
      p3 = sext16(press_cal_lo[47:32]);
      p4 = sext16(press_cal_lo[63:48]);
      p5 = sext16(press_cal_hi[15:0]);
      p6 = sext16(press_cal_hi[31:16]);
      p7 = sext16(press_cal_hi[47:32]);
      p8 = sext16(press_cal_hi[63:48]);
      p9 = sext16(press_cal_p9);
      w1 = tf64 - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      w1 = sar64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
      w1 = sar64(((64'd1 << 47) + w1) * p1, 33);
      r.pascals  = '0;
      r.div_zero = (w1 == 64'd0);
      if (!r.div_zero) begin
         num = (((64'd1048576 - {44'd0, raw_p}) << 31) - w2) * 64'd3125;
         // truncating signed divide on magnitudes; MIN / -1 wraps to MIN
         na = num[63];
         nb = w1[63];
         ua = na ? -num : num;
         ub = nb ? -w1 : w1;
         q  = ua / ub;
         p  = (na != nb) ? -q : q;
         ph = sar64(p, 13);
         e1 = sar64(p9 * ph * ph, 25);
         e2 = sar64(p8 * p, 19);
         p  = sar64(p + e1 + e2, 8) + p7 * 64'd16;
         if (!p[63]) begin
            p = p >> 8;
            r.pascals = (p > 64'd262143) ? 18'h3FFFF : p[17:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // handshakes complete at the next rising edge; sample mid-cycle
   always @(negedge clock) begin
      comp_result_type want;
      req_ready_seen <= req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.fine)
               report_mismatch($sformatf("fine %h exp %h", rsp_tdata[31:0], want.fine));
            if (rsp_tdata[47:32] !== want.centi)
               report_mismatch($sformatf("centi %h exp %h", rsp_tdata[47:32], want.centi));
            if (rsp_tdata[65:48] !== want.pascals)
               report_mismatch($sformatf("pa %h exp %h", rsp_tdata[65:48], want.pascals));
            if (rsp_tdata[71:66] !== 6'd0)
               report_mismatch($sformatf("fill bits %h", rsp_tdata[71:66]));
            if (rsp_tuser !== want.div_zero)
               report_mismatch($sformatf("div_zero %b exp %b", rsp_tuser, want.div_zero));
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {raw_p, raw_t};
      do @(posedge clock); while (!req_ready_seen);
      pending_results.push_back(compensate(raw_t, raw_p));
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // drain, let the pipeline empty, then load all four calibration words
   task automatic load_calibration(input logic [47:0] tc, input logic [63:0] lo,
                                   input logic [63:0] hi, input logic [15:0] p9);
      wait_results_done();
      repeat (TOTAL_LAT + 10) @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_TEMP_COEFFS; csr_wdata <= {16'd0, tc};
      @(posedge clock);
      csr_index <= CSR_PRESS_LOW; csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_PRESS_HIGH; csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_PRESS_NINE; csr_wdata <= {48'd0, p9};
      @(posedge clock);
      csr_we <= 1'b0;
      temp_cal = tc; press_cal_lo = lo; press_cal_hi = hi; press_cal_p9 = p9;
   endtask

   localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_LO   = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
   localparam logic [63:0] TYP_HI   = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
   localparam logic [15:0] TYP_P9   = 16'd6000;

   // calibration at reset is all zero, so the divisor is zero
   task automatic test_reset_calibration();
      gap_pct = 0; stall_pct = 0;
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd519888, 20'd415148);
   endtask

   task automatic test_directed_extremes();
      load_calibration(TYP_TEMP, TYP_LO, TYP_HI, TYP_P9);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'd0);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'hAAAAA, 20'h55555);
      // full-scale raw temperature with the largest then the smallest T2 coefficient
      load_calibration({16'd0, 16'h7FFF, 16'd0}, TYP_LO, TYP_HI, TYP_P9);
      send_reading(20'hFFFFF, 20'd300000);
      load_calibration({16'd0, 16'h8000, 16'd0}, TYP_LO, TYP_HI, TYP_P9);
      send_reading(20'hFFFFF, 20'd300000);
      // zero P1 forces a zero divisor with live temperature
      load_calibration(TYP_TEMP, {TYP_LO[63:16], 16'd0}, TYP_HI, TYP_P9);
      send_reading(20'd519888, 20'd415148);
      send_reading(20'hFFFFF, 20'd1);
      load_calibration('1, '1, '1, '1);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
                       {4{16'h8000}}, 16'h8000);
      send_reading(20'h12345, 20'hEDCBA);
      send_reading(20'hFFFFF, 20'd0);
      load_calibration({16'h7FFF, 16'h7FFF, 16'd0}, {{3{16'h7FFF}}, 16'hFFFF},
                       {4{16'h7FFF}}, 16'h7FFF);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'h80000, 20'h80000);
   endtask

   function automatic logic [15:0] nudge(input logic [15:0] w);
      return ($urandom_range(3) == 0) ? 16'($urandom) : w + 16'($urandom_range(0, 64)) - 16'd32;
   endfunction

   task automatic test_random_readings();
      logic [47:0] tc;
      logic [63:0] lo, hi;
      logic [15:0] p9;
      logic [19:0] rt, rp;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase % 4 == 3) begin
            tc = 48'({$urandom, $urandom}); lo = {$urandom, $urandom};
            hi = {$urandom, $urandom}; p9 = 16'($urandom);
         end else begin
            tc = {nudge(TYP_TEMP[47:32]), nudge(TYP_TEMP[31:16]), nudge(TYP_TEMP[15:0])};
            lo = {nudge(TYP_LO[63:48]), nudge(TYP_LO[47:32]), nudge(TYP_LO[31:16]),
                  nudge(TYP_LO[15:0])};
            hi = {nudge(TYP_HI[63:48]), nudge(TYP_HI[47:32]), nudge(TYP_HI[31:16]),
                  nudge(TYP_HI[15:0])};
            p9 = nudge(TYP_P9);
         end
         load_calibration(tc, lo, hi, p9);
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 76; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 76; end
            default: begin gap_pct = 12; stall_pct = 12; end
         endcase
         for (int n = 0; n < 236; n++) begin
            // hold off until the pipeline has fully emptied
            if (n == 50) wait_results_done();
            if ($urandom_range(3) == 0) begin
               rt = 20'($urandom); rp = 20'($urandom);
            end else begin
               rt = 20'($urandom_range(380000, 620000));
               rp = 20'($urandom_range(200000, 700000));
            end
            send_reading(rt, rp);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_we = 1'b0; csr_index = CSR_TEMP_COEFFS; csr_wdata = '0;
      temp_cal = '0; press_cal_lo = '0; press_cal_hi = '0; press_cal_p9 = '0;
      gap_pct = 0; stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calibration();
      test_directed_extremes();
      test_random_readings();
      wait_results_done();
      repeat (TOTAL_LAT + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("baro_temp_pressure_compensation test passed");
      end else begin
         $display("baro_temp_pressure_compensation test failed");
      end
      $finish;
   end

endmodule
